>>> rtl/weighted_channel_hop_scheduler_defines.svh
// ============================================================================
// Weighted channel hop scheduler - assertion macros
// Shared concurrent assertion forms used by the port checker.
// ============================================================================
`ifndef WEIGHTED_CHANNEL_HOP_SCHEDULER_DEFINES_SVH
`define WEIGHTED_CHANNEL_HOP_SCHEDULER_DEFINES_SVH

// Overlapping implication, checked outside reset.
`define WCHS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication, checked outside reset.
`define WCHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wchs_pkg.sv
// ============================================================================
// Weighted channel hop scheduler - package
// Widths, register indices, reset values and the accumulator saturation.
// ============================================================================
`default_nettype none

package wchs_pkg;

    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CHAN_OUT_W = 8;
    localparam int SLOT_OUT_W = 3;
    localparam int SC_W       = 4;
    localparam int PRIO_W     = 8;
    localparam int PW_W       = 4;
    localparam int DWELL_W    = 16;
    localparam int DEFER_W    = 10;
    localparam int ACC_W      = 8;
    localparam int CALC_W     = 12;
    localparam int TOT_W      = 9;
    // Active slot count, holds 0 to 15.
    localparam int CNT_W      = 5;
    localparam int PCNT_W     = 4;

    localparam logic [PW_W-1:0]    PW_RESET    = 4'd1;
    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd100;
    localparam logic [DEFER_W-1:0] DEFER_RESET = 10'd100;

    localparam logic signed [CALC_W-1:0] ACC_MAX = 12'sd127;
    localparam logic signed [CALC_W-1:0] ACC_MIN = -12'sd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOT_COUNT      = 3'd0,
        REG_CHANNEL_LIST    = 3'd1,
        REG_PRIORITY_MASK   = 3'd2,
        REG_PRIORITY_WEIGHT = 3'd3,
        REG_DWELL_TICKS     = 3'd4,
        REG_MAX_DEFER_TICKS = 3'd5
    } t_cfg_reg;

    typedef logic signed [ACC_W-1:0] t_acc;

    // Clamp a widened accumulator result back into the signed 8-bit range.
    function automatic t_acc sat_acc(input logic signed [CALC_W-1:0] v);
        t_acc res;
        if (v > ACC_MAX) begin
            res = t_acc'(ACC_MAX);
        end else if (v < ACC_MIN) begin
            res = t_acc'(ACC_MIN);
        end else begin
            res = t_acc'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/weighted_channel_hop_scheduler.sv
// ============================================================================
// Weighted channel hop scheduler
// Smooth weighted round-robin channel hopping with dwell and burst deferral.
// ============================================================================
// Each input transaction is one tick. The block accepts one tick per clock
// cycle while its input is not stalled and returns the hop it causes, if any,
// through the result register: the tick is captured in an input register,
// and from there the whole hop decision (weight add on every slot, the argmax
// tree, the total subtraction and the channel select) runs as one pass of
// combinational logic into the result register. That single pass between the
// two registers sets the rate. The input side stalls only while a result sits
// in the result register and the output side is stalled; there is no clearing
// pass after reset.
`default_nettype none

module weighted_channel_hop_scheduler
    import wchs_pkg::*;
#(
    parameter int SLOTS        = 8,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    // Tick input channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_hop_enable,
    input  wire logic                  i_burst_active,
    // Hop result channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [CHAN_OUT_W-1:0]      o_channel,
    output logic [SLOT_OUT_W-1:0]      o_slot
);

    // Width of a slot index, and the leaf count of the argmax tree, which is
    // the slot count rounded up to a power of two.
    localparam int SIDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TREE_N     = 1 << SIDX_W;
    localparam int NODES      = 2 * TREE_N - 1;
    // Channel bits that survive the 8-bit output mask.
    localparam int CH_W       = (CHANNEL_BITS > CHAN_OUT_W) ? CHAN_OUT_W : CHANNEL_BITS;
    // The channel list is padded with zeros so that slots lying past its end
    // read channel zero without any range check.
    localparam int EXT_W      = CFG_W + SLOTS * CHANNEL_BITS;
    // Only the first eight slots have a bit in the priority mask.
    localparam int PRIO_SLOTS = (SLOTS < PRIO_W) ? SLOTS : PRIO_W;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [SC_W-1:0]    r_slot_count;
    logic [CFG_W-1:0]   r_channel_list;
    logic [PRIO_W-1:0]  r_prio_mask;
    logic [PW_W-1:0]    r_prio_weight;
    logic [DWELL_W-1:0] r_dwell_ticks;
    logic [DEFER_W-1:0] r_max_defer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count   <= '0;
            r_channel_list <= '0;
            r_prio_mask    <= '0;
            r_prio_weight  <= PW_RESET;
            r_dwell_ticks  <= DWELL_RESET;
            r_max_defer    <= DEFER_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_SLOT_COUNT:      r_slot_count   <= i_cfg_data[SC_W-1:0];
                REG_CHANNEL_LIST:    r_channel_list <= i_cfg_data;
                REG_PRIORITY_MASK:   r_prio_mask    <= i_cfg_data[PRIO_W-1:0];
                REG_PRIORITY_WEIGHT: r_prio_weight  <= i_cfg_data[PW_W-1:0];
                REG_DWELL_TICKS:     r_dwell_ticks  <= i_cfg_data[DWELL_W-1:0];
                REG_MAX_DEFER_TICKS: r_max_defer    <= i_cfg_data[DEFER_W-1:0];
                default: begin
                    // Indices beyond the register list are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------------
    // r_in_* is the input register; r_out_* is the result register. A tick
    // held in the input register moves on when the result register is empty
    // or is being emptied in this cycle.
    logic r_in_valid;
    logic r_in_enable;
    logic r_in_burst;
    logic r_out_valid;
    logic [CHAN_OUT_W-1:0] r_channel;
    logic [SLOT_OUT_W-1:0] r_slot;

    logic advance;
    logic in_accept;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    // ------------------------------------------------------------------------
    // Schedule state
    // ------------------------------------------------------------------------
    t_acc               r_acc [SLOTS];
    logic [DWELL_W-1:0] r_dwell_count;
    logic [DEFER_W-1:0] r_defer_count;
    logic               r_started;

    // ------------------------------------------------------------------------
    // Slot activity and weights
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0]  act_cnt;
    logic [SLOTS-1:0]  act;
    logic [PW_W-1:0]   pw;
    logic [PW_W-1:0]   weight [SLOTS];
    logic [PCNT_W-1:0] prio_cnt;
    logic [7:0]        prio_extra;
    logic [TOT_W-1:0]  total;

    always_comb begin
        // A slot count above the number of slots counts as all of them.
        if (CNT_W'(r_slot_count) > CNT_W'(SLOTS)) begin
            act_cnt = CNT_W'(SLOTS);
        end else begin
            act_cnt = CNT_W'(r_slot_count);
        end
        pw = (r_prio_weight > PW_RESET) ? r_prio_weight : PW_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            act[i]    = CNT_W'(i) < act_cnt;
            weight[i] = PW_RESET;
        end
        prio_cnt = '0;
        for (int i = 0; i < PRIO_SLOTS; i++) begin
            if (r_prio_mask[i]) begin
                weight[i] = pw;
            end
            prio_cnt = prio_cnt + PCNT_W'(r_prio_mask[i] && act[i]);
        end
        // Total weight is one per active slot plus the extra weight carried
        // by each active priority slot.
        prio_extra = 8'(pw - PW_RESET) * 8'(prio_cnt);
        total      = TOT_W'(act_cnt) + TOT_W'(prio_extra);
    end

    // ------------------------------------------------------------------------
    // Accumulator update and argmax
    // ------------------------------------------------------------------------
    t_acc              acc_add  [SLOTS];
    t_acc              acc_new  [SLOTS];
    t_acc              node_val [NODES];
    logic [SIDX_W-1:0] node_idx [NODES];
    logic              node_ok  [NODES];
    logic [SIDX_W-1:0] best;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (act[i]) begin
                acc_add[i] = sat_acc(CALC_W'(r_acc[i])
                                     + CALC_W'($signed({1'b0, weight[i]})));
            end else begin
                acc_add[i] = r_acc[i];
            end
        end
        // Leaves of the tree; padding leaves and inactive slots never win.
        for (int i = 0; i < TREE_N; i++) begin
            node_idx[TREE_N - 1 + i] = SIDX_W'(i);
            if (i < SLOTS) begin
                node_val[TREE_N - 1 + i] = acc_add[i];
                node_ok[TREE_N - 1 + i]  = act[i];
            end else begin
                node_val[TREE_N - 1 + i] = '0;
                node_ok[TREE_N - 1 + i]  = 1'b0;
            end
        end
        // The left child covers lower slot indices, so preferring it on a tie
        // selects the first slot holding the largest value.
        for (int k = TREE_N - 2; k >= 0; k--) begin
            if (node_ok[2*k+1] && (!node_ok[2*k+2] || node_val[2*k+1] >= node_val[2*k+2]))
            begin
                node_val[k] = node_val[2*k+1];
                node_idx[k] = node_idx[2*k+1];
                node_ok[k]  = node_ok[2*k+1];
            end else begin
                node_val[k] = node_val[2*k+2];
                node_idx[k] = node_idx[2*k+2];
                node_ok[k]  = node_ok[2*k+2];
            end
        end
        best = node_idx[0];
        for (int i = 0; i < SLOTS; i++) begin
            if (SIDX_W'(i) == best) begin
                acc_new[i] = sat_acc(CALC_W'(acc_add[i])
                                     - CALC_W'($signed({1'b0, total})));
            end else begin
                acc_new[i] = acc_add[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Channel and slot of the chosen entry
    // ------------------------------------------------------------------------
    logic [EXT_W-1:0]             ext_list;
    logic [CHAN_OUT_W-1:0]        slot_chan [SLOTS];
    logic [CHAN_OUT_W-1:0]        best_chan;
    logic [SIDX_W+SLOT_OUT_W-1:0] best_wide;

    always_comb begin
        ext_list = {(EXT_W - CFG_W)'(0), r_channel_list};
        for (int i = 0; i < SLOTS; i++) begin
            slot_chan[i] = CHAN_OUT_W'(ext_list[i*CHANNEL_BITS +: CH_W]);
        end
        best_chan = slot_chan[best];
        best_wide = {SLOT_OUT_W'(0), best};
    end

    // ------------------------------------------------------------------------
    // Dwell and deferral decision
    // ------------------------------------------------------------------------
    logic [DWELL_W-1:0] dwell;
    logic [DWELL_W-1:0] dwell_inc;
    logic               dwell_done;
    logic               run;
    logic               defer_now;
    logic               hop;

    always_comb begin
        // A dwell of zero behaves as one: hop on every tick not deferred by a burst.
        dwell      = (r_dwell_ticks == '0) ? DWELL_W'(1) : r_dwell_ticks;
        dwell_inc  = (r_dwell_count < dwell) ? r_dwell_count + DWELL_W'(1) : r_dwell_count;
        dwell_done = dwell_inc >= dwell;
        run        = r_in_enable && (act_cnt != '0);
        defer_now  = r_started && dwell_done && r_in_burst && (r_defer_count < r_max_defer);
        // The first enabled tick hops at once.
        hop        = run && (!r_started || (dwell_done && !defer_now));
    end

    // ------------------------------------------------------------------------
    // Registers: control and schedule state
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_dwell_count <= '0;
            r_defer_count <= '0;
            r_started     <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= hop;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                if (!run) begin
                    // Disabled tick or no slots: the schedule starts over.
                    r_dwell_count <= '0;
                    r_defer_count <= '0;
                    r_started     <= 1'b0;
                    for (int i = 0; i < SLOTS; i++) begin
                        r_acc[i] <= '0;
                    end
                end else if (hop) begin
                    r_dwell_count <= '0;
                    r_defer_count <= '0;
                    r_started     <= 1'b1;
                    for (int i = 0; i < SLOTS; i++) begin
                        r_acc[i] <= acc_new[i];
                    end
                end else begin
                    r_dwell_count <= dwell_inc;
                    if (defer_now) begin
                        r_defer_count <= r_defer_count + DEFER_W'(1);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Registers: payload
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_enable <= i_hop_enable;
            r_in_burst  <= i_burst_active;
        end
        if (advance && hop) begin
            r_channel <= best_chan;
            r_slot    <= best_wide[SLOT_OUT_W-1:0];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_channel = r_channel;
    assign o_slot    = r_slot;

endmodule

`default_nettype wire

>>> rtl/wchs_checker.sv
// ============================================================================
// Weighted channel hop scheduler - port checker
// Watches the top level's ports and is bound to every instance of it.
// ============================================================================
`default_nettype none

`include "weighted_channel_hop_scheduler_defines.svh"

module wchs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_hop_enable,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_channel,
    input wire logic [2:0] o_slot
);

    // A result that is not taken stays offered unchanged.
    `WCHS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_channel) && $stable(o_slot), "stalled result changed")

    // The input side only stalls while a result waits on a stalled output.
    `WCHS_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a waiting result")

    // A disabled tick that moves through the block gives no result.
    `WCHS_ASSERT_NEXT(a_disabled_quiet, i_clk, i_rst_n, (i_valid && !o_stall && !i_hop_enable) ##1 !o_stall, !o_valid, "disabled tick produced a hop")

endmodule

bind weighted_channel_hop_scheduler wchs_checker u_wchs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_hop_enable (i_hop_enable),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_channel    (o_channel),
    .o_slot       (o_slot)
);

`default_nettype wire

>>> bench/tb_weighted_channel_hop_scheduler.sv
`timescale 1ns / 100ps
// ============================================================================
// Weighted channel hop scheduler - self-checking testbench
// Drives tick transactions through the scheduler under randomised
// back-pressure and compares every hop against a cycle-free predictor of the
// smooth weighted round-robin schedule, across many register settings.
// ============================================================================

module tb_weighted_channel_hop_scheduler;
    import wchs_pkg::*;

    localparam int NUM_SLOTS        = 8;
    // Margin for a tick that causes no hop to clear the input and result
    // registers before a register write.
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    // No correct run goes anywhere near this long without a transaction on
    // either channel: the longest is the deliberate receiver hold above.
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_PHASES    = 12;
    localparam int TICKS_PER_PHASE  = 120;

    typedef struct packed {
        logic hop_enable;
        logic burst_active;
    } t_tick;

    typedef struct packed {
        logic [CHAN_OUT_W-1:0] channel;
        logic [SLOT_OUT_W-1:0] slot;
    } t_hop;

    // How often each side of the block sits idle.
    typedef enum int {
        PACE_TX35_RX57,
        PACE_TX57_RX35,
        PACE_FREE
    } t_pace;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_W-1:0]      i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic                  i_hop_enable   = 1'b0;
    logic                  i_burst_active = 1'b0;
    logic                  i_stall        = 1'b0;
    wire                   o_stall;
    wire                   o_valid;
    wire [CHAN_OUT_W-1:0]  o_channel;
    wire [SLOT_OUT_W-1:0]  o_slot;

    weighted_channel_hop_scheduler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_hop_enable   (i_hop_enable),
        .i_burst_active (i_burst_active),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_channel      (o_channel),
        .o_slot         (o_slot)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Copy of the register file, kept as the block should hold it.
    // ------------------------------------------------------------------------
    logic [SC_W-1:0]    cfg_slot_count  = '0;
    logic [63:0]        cfg_channels    = '0;
    logic [PRIO_W-1:0]  cfg_prio_mask   = '0;
    logic [PW_W-1:0]    cfg_prio_weight = PW_RESET;
    logic [DWELL_W-1:0] cfg_dwell       = DWELL_RESET;
    logic [DEFER_W-1:0] cfg_max_defer   = DEFER_RESET;

    // Predicted schedule state.
    t_acc               sched_acc [NUM_SLOTS];
    logic [DWELL_W-1:0] sched_dwell   = '0;
    logic [DEFER_W-1:0] sched_defer   = '0;
    bit                 sched_started = 1'b0;

    t_tick tick_pending_q [$];
    t_hop  hop_expect_q [$];

    t_tick cur_tick;
    bit    tick_offered = 1'b0;
    t_pace pace         = PACE_TX35_RX57;
    bit    rx_hold_req  = 1'b0;
    int    rx_hold_left = 0;
    int    quiet_cycles = 0;
    int    fail_count   = 0;

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) sched_acc[i] = '0;
    end

    // ------------------------------------------------------------------------
    // Predictor of the hop schedule.
    // ------------------------------------------------------------------------

    // The accumulators saturate at both ends of the signed 8-bit range.
    function automatic t_acc clip_acc(input int v);
        t_acc r;
        if (v > 127) begin
            r = t_acc'(127);
        end else if (v < -128) begin
            r = t_acc'(-128);
        end else begin
            r = t_acc'(v);
        end
        return r;
    endfunction

    // Priority slots weigh the priority weight, but never less than one.
    function automatic int weight_of(input int s);
        int pw;
        pw = (cfg_prio_weight > 1) ? int'(cfg_prio_weight) : 1;
        if (s < 8 && cfg_prio_mask[s]) begin
            return pw;
        end
        return 1;
    endfunction

    // Apply one accepted tick to the predicted schedule and queue the hop that
    // it causes, if any.
    task automatic advance_schedule(input t_tick t);
        int   n;
        int   dwell;
        int   total;
        int   best;
        int   i;
        t_hop h;
        n     = (cfg_slot_count > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_slot_count);
        dwell = (cfg_dwell == 0) ? 1 : int'(cfg_dwell);
        // A disabled tick, or an empty slot list, clears the whole schedule.
        if (!t.hop_enable || n == 0) begin
            for (i = 0; i < NUM_SLOTS; i++) sched_acc[i] = '0;
            sched_dwell   = '0;
            sched_defer   = '0;
            sched_started = 1'b0;
            return;
        end
        // The first enabled tick hops at once; later hops wait for the dwell
        // and are then held back by a burst until the defer budget runs out.
        if (sched_started) begin
            if (sched_dwell < dwell) sched_dwell++;
            if (sched_dwell < dwell) return;
            if (t.burst_active && sched_defer < cfg_max_defer) begin
                sched_defer++;
                return;
            end
        end
        total = 0;
        best  = 0;
        for (i = 0; i < n; i++) total += weight_of(i);
        // Ties go to the lowest slot, as only a strictly larger value wins.
        for (i = 0; i < n; i++) begin
            sched_acc[i] = clip_acc(int'(sched_acc[i]) + weight_of(i));
            if (sched_acc[i] > sched_acc[best]) best = i;
        end
        sched_acc[best] = clip_acc(int'(sched_acc[best]) - total);
        sched_started   = 1'b1;
        sched_dwell     = '0;
        sched_defer     = '0;
        h.channel       = cfg_channels[best*8 +: 8];
        h.slot          = SLOT_OUT_W'(best);
        hop_expect_q    = {hop_expect_q, h};
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Register writes. Bits above a register's width carry random junk, which
    // the block has to ignore.
    // ------------------------------------------------------------------------
    function automatic logic [CFG_W-1:0] pad_junk(input logic [CFG_W-1:0] v, input int w);
        logic [CFG_W-1:0] r;
        r = {$urandom, $urandom};
        if (w >= CFG_W) return v;
        return (r << w) | (v & ((64'd1 << w) - 64'd1));
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_SLOT_COUNT:      cfg_slot_count  = value[SC_W-1:0];
            REG_CHANNEL_LIST:    cfg_channels    = value;
            REG_PRIORITY_MASK:   cfg_prio_mask   = value[PRIO_W-1:0];
            REG_PRIORITY_WEIGHT: cfg_prio_weight = value[PW_W-1:0];
            REG_DWELL_TICKS:     cfg_dwell       = value[DWELL_W-1:0];
            REG_MAX_DEFER_TICKS: cfg_max_defer   = value[DEFER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [SC_W-1:0] sc, input logic [63:0] chans,
                                 input logic [PRIO_W-1:0] mask, input logic [PW_W-1:0] pw,
                                 input logic [DWELL_W-1:0] dwell,
                                 input logic [DEFER_W-1:0] defer);
        write_reg(REG_SLOT_COUNT,      pad_junk(64'(sc), SC_W));
        write_reg(REG_CHANNEL_LIST,    chans);
        write_reg(REG_PRIORITY_MASK,   pad_junk(64'(mask), PRIO_W));
        write_reg(REG_PRIORITY_WEIGHT, pad_junk(64'(pw), PW_W));
        write_reg(REG_DWELL_TICKS,     pad_junk(64'(dwell), DWELL_W));
        write_reg(REG_MAX_DEFER_TICKS, pad_junk(64'(defer), DEFER_W));
    endtask

    // Mostly short dwells and small defer budgets so that hops stay frequent;
    // now and then the extremes of every register.
    task automatic random_setting();
        logic [SC_W-1:0]    sc;
        logic [63:0]        chans;
        logic [PRIO_W-1:0]  mask;
        logic [DWELL_W-1:0] dwell;
        logic [DEFER_W-1:0] defer;
        int                 p;
        p = $urandom_range(99);
        if (p < 10) begin
            sc = '0;
        end else if (p < 20) begin
            sc = SC_W'($urandom_range(15, 9));
        end else begin
            sc = SC_W'($urandom_range(8, 1));
        end
        p = $urandom_range(99);
        if (p < 10) begin
            chans = '0;
        end else if (p < 20) begin
            chans = '1;
        end else begin
            chans = {$urandom, $urandom};
        end
        p = $urandom_range(99);
        if (p < 15) begin
            mask = '0;
        end else if (p < 30) begin
            mask = '1;
        end else begin
            mask = PRIO_W'($urandom);
        end
        p = $urandom_range(99);
        if (p < 5) begin
            dwell = '0;
        end else if (p < 10) begin
            dwell = '1;
        end else if (p < 15) begin
            dwell = DWELL_W'($urandom);
        end else begin
            dwell = DWELL_W'($urandom_range(6, 1));
        end
        p = $urandom_range(99);
        if (p < 10) begin
            defer = '0;
        end else if (p < 15) begin
            defer = '1;
        end else begin
            defer = DEFER_W'($urandom_range(12, 1));
        end
        apply_setting(sc, chans, mask, PW_W'($urandom_range(15)), dwell, defer);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    task automatic queue_tick(input logic en, input logic burst, input int count);
        t_tick t;
        t.hop_enable   = en;
        t.burst_active = burst;
        repeat (count) tick_pending_q = {tick_pending_q, t};
    endtask

    // Hopping is enabled almost throughout, with bursts arriving in runs of
    // random length; stray burst ticks and the odd disable are the noise.
    task automatic queue_random_ticks(input int count);
        int    k;
        int    burst_run;
        t_tick t;
        burst_run = 0;
        for (k = 0; k < count; k++) begin
            if (burst_run == 0 && $urandom_range(99) < 12) begin
                burst_run = $urandom_range(40, 1);
            end
            t.hop_enable   = ($urandom_range(99) >= 3);
            t.burst_active = (burst_run > 0) ? 1'b1 : ($urandom_range(99) < 5);
            if (burst_run > 0) burst_run--;
            tick_pending_q = {tick_pending_q, t};
        end
    endtask

    // The block is idle once every tick has been taken, every hop has come
    // back, and a tick with no hop has had time to leave the pipeline.
    task automatic wait_quiet();
        while (tick_pending_q.size() != 0 || tick_offered || hop_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver of the tick channel. A stalled transaction is held unchanged;
    // while no tick is offered the payload carries random noise.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : tick_driver
        bit keep;
        bit go;
        int idle_pct;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            keep = 1'b0;
            if (i_valid) begin
                if (!o_stall) begin
                    advance_schedule(cur_tick);
                    tick_offered = 1'b0;
                end else begin
                    keep = 1'b1;
                end
            end
            if (!keep) begin
                case (pace)
                    PACE_TX35_RX57: idle_pct = 35;
                    PACE_TX57_RX35: idle_pct = 57;
                    default:        idle_pct = 0;
                endcase
                go = (tick_pending_q.size() != 0) && ($urandom_range(99) >= idle_pct);
                if (go) begin
                    cur_tick       = tick_pending_q.pop_front();
                    tick_offered   = 1'b1;
                    i_valid        <= 1'b1;
                    i_hop_enable   <= cur_tick.hop_enable;
                    i_burst_active <= cur_tick.burst_active;
                end else begin
                    i_valid        <= 1'b0;
                    i_hop_enable   <= 1'($urandom);
                    i_burst_active <= 1'($urandom);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor of the hop channel: checks each accepted transaction against the
    // oldest predicted hop and decides the stall for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : hop_monitor
        t_hop got;
        t_hop want;
        bit   stall_next;
        int   idle_pct;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.channel = o_channel;
                got.slot    = o_slot;
                if (hop_expect_q.size() == 0) begin
                    note_failure($sformatf("%0t: unexpected hop, channel %0h slot %0d",
                                           $realtime, got.channel, got.slot));
                end else begin
                    want = hop_expect_q.pop_front();
                    if (got.channel !== want.channel || got.slot !== want.slot) begin
                        note_failure($sformatf(
                            "%0t: hop mismatch, channel exp %0h got %0h, slot exp %0d got %0d",
                            $realtime, want.channel, got.channel, want.slot, got.slot));
                    end
                end
            end
            // A requested hold keeps the hop channel stalled for a long
            // stretch, so that the block backs up into its tick input.
            if (rx_hold_req) begin
                rx_hold_left = LONG_HOLD_CYCLES;
                rx_hold_req  = 1'b0;
            end
            if (rx_hold_left > 0) begin
                stall_next = 1'b1;
                rx_hold_left--;
            end else begin
                case (pace)
                    PACE_TX35_RX57: idle_pct = 57;
                    PACE_TX57_RX35: idle_pct = 35;
                    default:        idle_pct = 0;
                endcase
                stall_next = ($urandom_range(99) < idle_pct);
            end
            i_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if neither channel moves a transaction for far
    // longer than any correct run would allow.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence. Registers change only while the block is idle; the
    // schedule itself may still be running, since hop_enable often stays high
    // from one setting into the next.
    // ------------------------------------------------------------------------
    initial begin : sequencer
        int ph;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset settings no slot is in use, so no tick may hop.
        queue_tick(1'b1, 1'b0, 1);
        queue_tick(1'b1, 1'b1, 1);
        wait_quiet();

        // All eight slots, channels from 00 to ff, heavy end slots. A zero
        // dwell hops on every tick and a zero defer budget ignores bursts.
        apply_setting(4'd8, 64'hFF80_7E3C_A5C3_0100, 8'h81, 4'd15, 16'd0, 10'd0);
        queue_tick(1'b1, 1'b0, 1);
        queue_tick(1'b1, 1'b1, 1);
        queue_tick(1'b1, 1'b0, 1);
        queue_tick(1'b1, 1'b1, 3);
        // Disabling restarts the schedule from cleared accumulators.
        queue_tick(1'b0, 1'b1, 1);
        queue_tick(1'b1, 1'b0, 2);
        wait_quiet();

        // A slot count above the slot total, a zero priority weight acting as
        // one, and a burst that outlasts a defer budget of two.
        apply_setting(4'd15, 64'h0011_2233_4455_6677, 8'hFF, 4'd0, 16'd3, 10'd2);
        queue_tick(1'b1, 1'b0, 1);
        queue_tick(1'b1, 1'b1, 6);
        queue_tick(1'b1, 1'b0, 3);
        wait_quiet();

        // Shrink the slot list while the schedule keeps running.
        apply_setting(4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 8'h02, 4'd15, 16'd1, 10'd1);
        queue_tick(1'b1, 1'b0, 2);
        queue_tick(1'b1, 1'b1, 2);
        wait_quiet();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            pace = t_pace'(ph / 4);
            if (ph == 8) begin
                // One hop per enabled tick and the sender never idle, so the long
                // receiver hold fills the block and stalls its tick input.
                apply_setting(4'd8, {$urandom, $urandom}, PRIO_W'($urandom),
                              PW_W'($urandom), 16'd1, 10'd0);
                rx_hold_req = 1'b1;
            end else begin
                random_setting();
            end
            queue_random_ticks(TICKS_PER_PHASE);
            // No further tick is offered until every hop has come back.
            wait_quiet();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/wchs_pkg.sv
rtl/weighted_channel_hop_scheduler.sv
rtl/wchs_checker.sv
bench/tb_weighted_channel_hop_scheduler.sv
